>>> rtl/psm_pkg.sv
// Package for the loop sampler mixer: sizes, operation codes, block entry type.
// Used by pattern_sample_mixer_top.sv and psm_checker.sv under rtl, and by the testbench.
`timescale 1ns / 1ps
`default_nettype none
package psm_pkg;
    localparam int LAYER_COUNT      = 8;
    localparam int BLOCKS_PER_LAYER = 16;
    localparam int SAMPLE_DEPTH     = 65536;
    localparam int LAYER_W = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
    localparam int SLOT_W  = (BLOCKS_PER_LAYER > 1) ? $clog2(BLOCKS_PER_LAYER) : 1;
    localparam int ADDR_W  = $clog2(SAMPLE_DEPTH);
    localparam int BLK_W   = LAYER_W + SLOT_W;
    localparam int BLK_N   = LAYER_COUNT * BLOCKS_PER_LAYER;
    localparam int MEM_W   = LAYER_W + ADDR_W;
    localparam int MEM_N   = LAYER_COUNT * SAMPLE_DEPTH;
    localparam int ACC_W   = 16 + BLK_W + 1;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_SAMPLE  = 3'd1;
    localparam logic [2:0] OP_BLOCK   = 3'd2;
    localparam logic [2:0] OP_LAYER   = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;

    localparam logic CFG_FPB  = 1'b0;
    localparam logic CFG_LOOP = 1'b1;

    typedef struct packed {
        logic       enable;
        logic [7:0] start_bar;
        logic [7:0] length_bars;
    } blk_t;
endpackage
`default_nettype wire

>>> rtl/psm_ram.sv
// Generic single-port write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module psm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write, then registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/pattern_sample_mixer_top.sv
// Loop sampler mixer: one stereo frame per render tick word.
// Load words can follow back to back while the block is idle and no result is pending.
// A tick before the loop end walks all BLK_N block slots through one shared multiplier and
// separate left and right adders, each slot through MS, ME, CHK, IDX, RD, ACC, RD2, ACC2;
// past the loop end it skips them. A result waits in an output register; the next word is taken
// the cycle after it is sent. Reset (synchronous, aresetn low) clears block enables,
// layer table, frame counter and config to defaults; sample memory is undefined.
`timescale 1ns / 1ps
`default_nettype none
module pattern_sample_mixer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_operation,
    input  wire logic [2:0]  s_layer_index,
    input  wire logic [3:0]  s_block_slot,
    input  wire logic [15:0] s_sample_address,
    input  wire logic signed [15:0] s_sample_value,
    input  wire logic [7:0]  s_block_start_bar,
    input  wire logic [7:0]  s_block_length_bars,
    input  wire logic        s_block_enable,
    input  wire logic [1:0]  s_channel_count,
    input  wire logic [16:0] s_sample_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [15:0] m_left_sample,
    output logic signed [15:0] m_right_sample,
    output logic             m_clip_flag,
    output logic             m_loop_finished
);
    import psm_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOOP  = 4'd1;
    localparam logic [3:0] ST_BLK   = 4'd2;
    localparam logic [3:0] ST_MS    = 4'd3;
    localparam logic [3:0] ST_ME    = 4'd4;
    localparam logic [3:0] ST_CHK   = 4'd5;
    localparam logic [3:0] ST_IDX   = 4'd6;
    localparam logic [3:0] ST_RD    = 4'd7;
    localparam logic [3:0] ST_ACC   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;
    localparam logic [3:0] ST_RD2   = 4'd10;
    localparam logic [3:0] ST_ACC2  = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [23:0] fpb_reg;
    logic [7:0]  loop_reg;
    logic [31:0] fc_reg;

    logic [BLOCKS_PER_LAYER-1:0] en_reg [LAYER_COUNT];
    logic [1:0]  chan_reg [LAYER_COUNT];
    logic [16:0] len_reg  [LAYER_COUNT];

    logic [BLK_W-1:0] bi_reg;
    logic [8:0]  mul_a_reg;
    logic [31:0] prod_reg;
    logic [31:0] s_reg;
    logic [32:0] e_reg;
    logic [31:0] off_reg;
    logic [16:0] idx_reg;
    logic        idx_ok_reg;
    logic        ch_reg;
    logic signed [ACC_W-1:0] accl_reg, accr_reg;
    logic [15:0] out_l_reg, out_r_reg;
    logic        out_clip_reg, out_fin_reg, out_valid_reg;

    blk_t blk_rd;
    logic [15:0] smp_rd;

    wire accept = s_valid && s_ready;
    wire [LAYER_W-1:0] cur_layer = bi_reg[BLK_W-1 -: LAYER_W];
    wire [SLOT_W-1:0]  cur_slot  = bi_reg[SLOT_W-1:0];
    wire layer_ok = 32'(s_layer_index) < LAYER_COUNT;
    wire slot_ok  = 32'(s_block_slot) < BLOCKS_PER_LAYER;
    wire addr_ok  = 32'(s_sample_address) < SAMPLE_DEPTH;
    wire [LAYER_W-1:0] in_layer = s_layer_index[LAYER_W-1:0];

    // fetch the next block entry while the current one finishes its channels
    wire [BLK_W-1:0] blk_raddr = (state_reg == ST_RD2 || state_reg == ST_ACC2)
                                 ? bi_reg + BLK_W'(1) : bi_reg;

    assign s_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;

    // block table memory
    psm_ram #(.WIDTH($bits(blk_t)), .DEPTH(BLK_N)) u_blk (
        .aclk (aclk),
        .we   (accept && s_operation == OP_BLOCK && layer_ok && slot_ok),
        .waddr({in_layer, s_block_slot[SLOT_W-1:0]}),
        .wdata({s_block_enable, s_block_start_bar, s_block_length_bars}),
        .raddr(blk_raddr),
        .rdata(blk_rd)
    );

    // sample memory, all layers stacked
    psm_ram #(.WIDTH(16), .DEPTH(MEM_N)) u_smp (
        .aclk (aclk),
        .we   (accept && s_operation == OP_SAMPLE && layer_ok && addr_ok),
        .waddr({in_layer, s_sample_address[ADDR_W-1:0]}),
        .wdata(s_sample_value),
        .raddr({cur_layer, idx_reg[ADDR_W-1:0]}),
        .rdata(smp_rd)
    );

    // shared multiplier: bar count times frames per bar, full 33-bit product
    wire [32:0] mul_out = 33'(mul_a_reg) * 33'(fpb_reg);
    wire [1:0]  nch = chan_reg[cur_layer];
    wire [32:0] off_sh = (nch == 2'd2) ? {off_reg, 1'b0} : {1'b0, off_reg};
    wire [32:0] idx_full = off_sh + {32'd0, ch_reg};
    wire signed [ACC_W-1:0] smp_ext = ACC_W'(signed'(smp_rd));
    wire last_blk = (bi_reg == BLK_W'(BLK_N - 1));

    function automatic logic [16:0] sat(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(32767))       sat = {1'b1, 16'h7FFF};
        else if (v < -ACC_W'(32768)) sat = {1'b1, 16'h8000};
        else                          sat = {1'b0, v[15:0]};
    endfunction
    wire [16:0] sat_l = sat(accl_reg);
    wire [16:0] sat_r = sat(accr_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && s_operation == OP_TICK) state_next = ST_LOOP;
            ST_LOOP: state_next = ST_BLK;
            ST_BLK:  state_next = (fc_reg >= prod_reg) ? ST_OUT : ST_MS;
            ST_MS:   state_next = ST_ME;
            ST_ME:   state_next = ST_CHK;
            ST_CHK:  state_next = ST_IDX;
            ST_IDX:  state_next = ST_RD;
            ST_RD:   state_next = ST_ACC;
            ST_ACC:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_ACC2;
            ST_ACC2: state_next = last_blk ? ST_OUT : ST_MS;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fpb_reg       <= 24'd88200;
            loop_reg      <= 8'd4;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int l = 0; l < LAYER_COUNT; l++) begin
                en_reg[l]   <= '0;
                chan_reg[l] <= 2'd1;
                len_reg[l]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            // config writes
            if (cfg_valid) begin
                if (cfg_index == CFG_FPB) fpb_reg <= cfg_data;
                else                       loop_reg <= cfg_data[7:0];
            end
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            // load words
            if (accept) begin
                case (s_operation)
                    OP_BLOCK: if (layer_ok && slot_ok)
                        en_reg[in_layer][s_block_slot[SLOT_W-1:0]] <= s_block_enable;
                    OP_LAYER: if (layer_ok) begin
                        chan_reg[in_layer] <= (s_channel_count == 2'd3) ? 2'd2
                                                                        : s_channel_count;
                        len_reg[in_layer] <= (32'(s_sample_count) > SAMPLE_DEPTH)
                                             ? 17'(SAMPLE_DEPTH) : s_sample_count;
                    end
                    OP_RESTART: fc_reg <= '0;
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT) begin
                out_valid_reg <= 1'b1;
                if (!out_fin_reg) fc_reg <= fc_reg + 32'd1;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                bi_reg    <= '0;
                mul_a_reg <= {1'b0, loop_reg};
                accl_reg  <= '0;
                accr_reg  <= '0;
            end
            ST_LOOP: prod_reg <= mul_out[31:0];
            ST_BLK: begin
                out_fin_reg <= (fc_reg >= prod_reg);
                mul_a_reg   <= {1'b0, blk_rd.start_bar};
            end
            ST_MS: begin
                s_reg     <= mul_out[31:0];
                mul_a_reg <= 9'(blk_rd.start_bar) + 9'(blk_rd.length_bars);
            end
            ST_ME: e_reg <= mul_out;
            ST_CHK: begin
                off_reg <= fc_reg - s_reg;
                if (!blk_rd.enable || !en_reg[cur_layer][cur_slot]
                    || fc_reg < s_reg || {1'b0, fc_reg} >= e_reg)
                    e_reg <= '0;
                ch_reg <= 1'b0;
            end
            ST_IDX, ST_ACC: begin
                idx_reg    <= idx_full[16:0];
                idx_ok_reg <= (e_reg != 0) && (idx_full < 33'(len_reg[cur_layer]))
                              && (nch > 2'(ch_reg));
            end
            ST_RD: ch_reg <= 1'b1;
            ST_ACC2: begin
                if (idx_ok_reg) accr_reg <= accr_reg + smp_ext;
                bi_reg    <= bi_reg + 1'b1;
                mul_a_reg <= 9'(blk_rd.start_bar);
            end
            ST_OUT: begin
                out_l_reg    <= out_fin_reg ? 16'd0 : sat_l[15:0];
                out_r_reg    <= out_fin_reg ? 16'd0 : sat_r[15:0];
                out_clip_reg <= out_fin_reg ? 1'b0 : (sat_l[16] | sat_r[16]);
            end
            default: ;
        endcase
        if (state_reg == ST_ACC && idx_ok_reg) accl_reg <= accl_reg + smp_ext;
    end

    assign m_valid         = out_valid_reg;
    assign m_left_sample   = out_l_reg;
    assign m_right_sample  = out_r_reg;
    assign m_clip_flag     = out_clip_reg;
    assign m_loop_finished = out_fin_reg;
endmodule
`default_nettype wire

>>> rtl/psm_checker.sv
// Port-level checks for the loop sampler mixer, bound to the top level.
// Depends on pattern_sample_mixer_top ports and psm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [2:0]  s_operation,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_left_sample,
    input wire logic [15:0] m_right_sample,
    input wire logic        m_clip_flag,
    input wire logic        m_loop_finished
);
    import psm_pkg::*;

    a_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_loop_finished |-> m_left_sample == 16'd0
            && m_right_sample == 16'd0 && !m_clip_flag)
        else $error("finished frame not silent");
    a_noready_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("word taken while result pending");
    a_load_noout: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation != OP_TICK |=> !m_valid)
        else $error("load word made a result");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_sample)
            && $stable(m_right_sample) && $stable(m_clip_flag)
            && $stable(m_loop_finished))
        else $error("result dropped");
endmodule

bind pattern_sample_mixer_top psm_checker u_psm_checker (.*);
`default_nettype wire

>>> test/tb_pattern_sample_mixer_top.sv
// Testbench for the loop sampler mixer: directed, random and backpressure tests.
// Predicts every frame in-line and checks each result word; depends on rtl/psm_pkg.sv
// and rtl/pattern_sample_mixer_top.sv.
`timescale 1ns / 1ps
module tb_pattern_sample_mixer_top;
    import psm_pkg::*;

    // spare operation codes that the block must ignore
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int SETTLE_CYCLES = 600;

    typedef struct {
        logic [2:0]         op;
        logic [2:0]         layer;
        logic [3:0]         slot;
        logic [15:0]        addr;
        logic signed [15:0] value;
        logic [7:0]         start_bar;
        logic [7:0]         len_bars;
        logic               en;
        logic [1:0]         chans;
        logic [16:0]        count;
    } word_t;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               clip;
        logic               finished;
    } frame_t;

    logic aclk = 0;
    logic aresetn;
    logic cfg_valid, cfg_ready, cfg_index;
    logic [23:0] cfg_data;
    logic s_valid, s_ready;
    logic [2:0] s_operation, s_layer_index;
    logic [3:0] s_block_slot;
    logic [15:0] s_sample_address;
    logic signed [15:0] s_sample_value;
    logic [7:0] s_block_start_bar, s_block_length_bars;
    logic s_block_enable;
    logic [1:0] s_channel_count;
    logic [16:0] s_sample_count;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_left_sample, m_right_sample;
    logic m_clip_flag, m_loop_finished;

    pattern_sample_mixer_top u_dut (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_operation, .s_layer_index, .s_block_slot,
        .s_sample_address, .s_sample_value, .s_block_start_bar,
        .s_block_length_bars, .s_block_enable, .s_channel_count, .s_sample_count,
        .m_valid, .m_ready, .m_left_sample, .m_right_sample, .m_clip_flag,
        .m_loop_finished
    );

    always #5 aclk = ~aclk;

    // mirror of the mixer state
    logic [23:0] fpb_q;
    logic [7:0]  loop_bars_q;
    logic [31:0] frame_q;
    logic        blk_en [LAYER_COUNT][BLOCKS_PER_LAYER];
    logic [7:0]  blk_start [LAYER_COUNT][BLOCKS_PER_LAYER];
    logic [7:0]  blk_len [LAYER_COUNT][BLOCKS_PER_LAYER];
    int          layer_chans [LAYER_COUNT];
    int          layer_len [LAYER_COUNT];
    bit signed [15:0] sample_mem [LAYER_COUNT][SAMPLE_DEPTH];
    bit          sample_written [LAYER_COUNT][SAMPLE_DEPTH];

    frame_t frame_q_exp [$];
    int     mismatches = 0;
    int     hold_left = 0;
    bit     quiet = 0;

    // update the mirror for one accepted word; ticks queue the expected frame
    task automatic apply_word(input word_t w);
        logic [63:0] s, e, idx, loop_end;
        int acc [2];
        bit clip;
        frame_t f;
        case (w.op)
            OP_SAMPLE: begin
                sample_mem[w.layer][w.addr] = w.value;
                sample_written[w.layer][w.addr] = 1;
            end
            OP_BLOCK: begin
                blk_en[w.layer][w.slot] = w.en;
                blk_start[w.layer][w.slot] = w.start_bar;
                blk_len[w.layer][w.slot] = w.len_bars;
            end
            OP_LAYER: begin
                layer_chans[w.layer] = (w.chans > 2) ? 2 : w.chans;
                layer_len[w.layer] = (w.count > SAMPLE_DEPTH) ? SAMPLE_DEPTH : w.count;
            end
            OP_RESTART: frame_q = 0;
            OP_TICK: begin
                loop_end = 64'(loop_bars_q) * 64'(fpb_q);
                acc[0] = 0;
                acc[1] = 0;
                clip = 0;
                f.finished = (64'(frame_q) >= loop_end);
                if (!f.finished) begin
                    for (int l = 0; l < LAYER_COUNT; l++)
                        for (int b = 0; b < BLOCKS_PER_LAYER; b++) begin
                            s = 64'(blk_start[l][b]) * fpb_q;
                            e = (64'(blk_start[l][b]) + blk_len[l][b]) * fpb_q;
                            if (blk_en[l][b] && frame_q >= s && frame_q < e)
                                for (int ch = 0; ch < layer_chans[l]; ch++) begin
                                    idx = (frame_q - s) * layer_chans[l] + ch;
                                    if (idx < layer_len[l])
                                        acc[ch] += sample_mem[l][idx];
                                end
                        end
                    for (int ch = 0; ch < 2; ch++) begin
                        if (acc[ch] > 32767) begin
                            acc[ch] = 32767;
                            clip = 1;
                        end else if (acc[ch] < -32768) begin
                            acc[ch] = -32768;
                            clip = 1;
                        end
                    end
                    frame_q = frame_q + 1;
                end
                f.left = 16'(acc[0]);
                f.right = 16'(acc[1]);
                f.clip = clip;
                frame_q_exp.insert(frame_q_exp.size(), f);
            end
            default: ;
        endcase
    endtask

    // offer one word, hold it until taken, then update the mirror
    task automatic send_word(input word_t w);
        if (!quiet) begin
            while ($urandom_range(99) < 13) begin
                s_valid <= 0;
                @(posedge aclk);
            end
        end
        s_valid <= 1;
        s_operation <= w.op;
        s_layer_index <= w.layer;
        s_block_slot <= w.slot;
        s_sample_address <= w.addr;
        s_sample_value <= w.value;
        s_block_start_bar <= w.start_bar;
        s_block_length_bars <= w.len_bars;
        s_block_enable <= w.en;
        s_channel_count <= w.chans;
        s_sample_count <= w.count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_word(w);
    endtask

    function automatic word_t rand_word(input logic [2:0] op);
        word_t w;
        w.op = op;
        w.layer = 3'($urandom_range(0, 7));
        w.slot = 4'($urandom_range(0, 15));
        w.addr = 16'($urandom);
        w.value = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'sh7fff : 16'sh8000)
                                           : 16'($urandom);
        w.start_bar = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        w.len_bars = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        w.en = ($urandom_range(3) != 0);
        w.chans = 2'($urandom);
        w.count = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 300));
        return w;
    endfunction

    task automatic send_op(input logic [2:0] op, input logic [2:0] layer,
                           input logic [3:0] slot, input logic [15:0] addr,
                           input logic signed [15:0] value, input logic [7:0] sb,
                           input logic [7:0] lb, input logic en, input logic [1:0] cc,
                           input logic [16:0] cnt);
        word_t w;
        w = '{op, layer, slot, addr, value, sb, lb, en, cc, cnt};
        send_word(w);
    endtask

    // write any sample the next frame reads that was never loaded, then tick
    task automatic send_tick();
        logic [63:0] s, e, idx;
        word_t w;
        if (64'(frame_q) < 64'(loop_bars_q) * fpb_q)
            for (int l = 0; l < LAYER_COUNT; l++)
                for (int b = 0; b < BLOCKS_PER_LAYER; b++) begin
                    s = 64'(blk_start[l][b]) * fpb_q;
                    e = (64'(blk_start[l][b]) + blk_len[l][b]) * fpb_q;
                    if (blk_en[l][b] && frame_q >= s && frame_q < e)
                        for (int ch = 0; ch < layer_chans[l]; ch++) begin
                            idx = (frame_q - s) * layer_chans[l] + ch;
                            if (idx < layer_len[l] && !sample_written[l][idx]) begin
                                w = rand_word(OP_SAMPLE);
                                w.layer = 3'(l);
                                w.addr = 16'(idx);
                                send_word(w);
                            end
                        end
                end
        send_word(rand_word(OP_TICK));
    endtask

    // drop the input, wait for all frames, let the block settle, then write one register
    task automatic write_reg(input logic idx, input logic [23:0] data);
        s_valid <= 0;
        while (frame_q_exp.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        if (idx == CFG_FPB) fpb_q = data;
        else loop_bars_q = data[7:0];
        @(posedge aclk);
    endtask

    // check each frame taken from the block
    always @(posedge aclk) begin
        frame_t x;
        if (aresetn && m_valid && m_ready) begin
            if (frame_q_exp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected frame at %0t", $realtime);
            end else begin
                x = frame_q_exp.pop_front();
                if (m_left_sample !== x.left || m_right_sample !== x.right ||
                    m_clip_flag !== x.clip || m_loop_finished !== x.finished) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("frame mismatch: exp L=%0d R=%0d clip=%0b fin=%0b, ",
                                 x.left, x.right, x.clip, x.finished,
                                 "got L=%0d R=%0d clip=%0b fin=%0b",
                                 m_left_sample, m_right_sample, m_clip_flag,
                                 m_loop_finished);
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    task automatic test_directed();
        send_op(OP_LAYER, 0, 0, 0, 0, 0, 0, 0, 1, 4);
        send_op(OP_LAYER, 1, 0, 0, 0, 0, 0, 0, 3, 131071);
        send_op(OP_LAYER, 2, 0, 0, 0, 0, 0, 0, 0, 65536);
        send_op(OP_SAMPLE, 7, 15, 16'hffff, 16'sh7fff, 0, 0, 0, 0, 0);
        send_op(OP_BLOCK, 0, 0, 0, 0, 0, 2, 1, 0, 0);
        send_op(OP_BLOCK, 0, 15, 0, 0, 0, 1, 1, 0, 0);
        send_op(OP_BLOCK, 1, 3, 0, 0, 0, 2, 1, 0, 0);
        send_op(OP_BLOCK, 2, 1, 0, 0, 0, 2, 1, 0, 0);
        send_op(OP_BLOCK, 7, 15, 0, 0, 8'hff, 8'hff, 1, 0, 0);
        send_op(OP_SAMPLE, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0, 0);
        send_op(OP_SAMPLE, 0, 0, 1, 16'sh8000, 0, 0, 0, 0, 0);
        send_op(OP_SPARE_5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_SPARE_6, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_SPARE_7, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        write_reg(CFG_FPB, 2);
        write_reg(CFG_LOOP, 1);
        repeat (4) send_tick();   // clip high, clip low, then past the loop
        send_op(OP_RESTART, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_op(OP_BLOCK, 0, 15, 0, 0, 0, 1, 0, 0, 0);
        send_tick();
        write_reg(CFG_LOOP, 0);
        send_tick();
        write_reg(CFG_LOOP, 8'hff);
        write_reg(CFG_FPB, 0);
        send_tick();
    endtask

    task automatic run_phase(input logic [23:0] fpb, input logic [7:0] loop_bars,
                             input int n);
        int r;
        write_reg(CFG_FPB, fpb);
        write_reg(CFG_LOOP, 24'(loop_bars));
        send_op(OP_RESTART, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 40) send_tick();
            else if (r < 60) send_word(rand_word(OP_SAMPLE));
            else if (r < 77) send_word(rand_word(OP_BLOCK));
            else if (r < 89) send_word(rand_word(OP_LAYER));
            else if (r < 94) send_word(rand_word(OP_RESTART));
            else send_word(rand_word(3'($urandom_range(5, 7))));
        end
    endtask

    task automatic test_random();
        run_phase(3, 4, 100);
        quiet = 1;
        run_phase(1, 8'hff, 100);
        quiet = 0;
        run_phase(24'($urandom_range(1, 8)), 8'($urandom_range(1, 40)), 100);
        run_phase(24'hffffff, 8'hff, 100);
        run_phase(24'($urandom), 8'($urandom), 100);
    endtask

    // stall the receiver well past one frame so the block backs up into its input
    task automatic test_backpressure();
        run_phase(2, 100, 0);
        hold_left = 3000;
        repeat (20) send_tick();
    endtask

    initial begin
        aresetn = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        s_valid = 0;
        s_operation = OP_TICK;
        s_layer_index = 0;
        s_block_slot = 0;
        s_sample_address = 0;
        s_sample_value = 0;
        s_block_start_bar = 0;
        s_block_length_bars = 0;
        s_block_enable = 0;
        s_channel_count = 0;
        s_sample_count = 0;
        fpb_q = 88200;
        loop_bars_q = 4;
        frame_q = 0;
        for (int l = 0; l < LAYER_COUNT; l++) begin
            layer_chans[l] = 1;
            layer_len[l] = 0;
            for (int b = 0; b < BLOCKS_PER_LAYER; b++) begin
                blk_en[l][b] = 0;
                blk_start[l][b] = 0;
                blk_len[l][b] = 0;
            end
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        s_valid <= 0;
        while (frame_q_exp.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && frame_q_exp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hard stop in case the block hangs
    initial begin
        #60_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
